### sv/i2crm_pkg.sv
// Shared types and constants for the I2C target register map.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package i2crm_pkg;

  localparam int REG_COUNT = 128;
  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);

  localparam logic [3:0] OP_READ_ADDR = 4'd0;
  localparam logic [3:0] OP_BYTE_SENT = 4'd1;
  localparam logic [3:0] OP_WRITE_ADDR = 4'd2;
  localparam logic [3:0] OP_RX_ACK = 4'd3;
  localparam logic [3:0] OP_RX_NACK = 4'd4;
  localparam logic [3:0] OP_BUS_ERROR = 4'd5;
  localparam logic [3:0] OP_LOCAL_WRITE = 4'd7;
  localparam logic [3:0] OP_LOCAL_READ = 4'd8;

  typedef struct packed {
    logic load;       // item accepted this cycle
    logic rd_ptr;     // read at the pointer
    logic rd_next;    // advance pointer and read there
    logic rd_local;   // read at local_address
    logic wr_ptr;     // write rx_byte at the pointer
    logic wr_local;   // write local_value at local_address
    logic set_ptr;    // load pointer from rx_byte
    logic clr_loaded; // new write transfer
    logic ack;
    logic stop;
  } cmd_t;

  typedef struct packed {
    logic loaded;     // pointer byte already received
    logic can_inc;    // pointer + 1 is inside the file
  } sts_t;

endpackage

`default_nettype wire

### sv/i2crm_ctrl.sv
// Controller: handshake state machine and operation decode.
// Depends on i2crm_pkg; drives commands into i2crm_dp.
`default_nettype none

module i2crm_ctrl
  import i2crm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] operation,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_OUT  = 2'b10
  } state_t;

  state_t state, state_next;
  logic accept;

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    cmd.load = accept;
    if (accept) begin
      unique case (operation)
        OP_READ_ADDR: begin
          cmd.rd_ptr = 1'b1;
          cmd.ack = 1'b1;
        end
        OP_BYTE_SENT: begin
          cmd.rd_next = sts.can_inc;
          cmd.ack = sts.can_inc;
        end
        OP_WRITE_ADDR: begin
          cmd.clr_loaded = 1'b1;
          cmd.ack = 1'b1;
        end
        OP_RX_ACK: begin
          cmd.set_ptr = !sts.loaded;
          cmd.wr_ptr = sts.loaded;
          cmd.ack = 1'b1;
        end
        OP_RX_NACK:     cmd.wr_ptr = 1'b1;
        OP_BUS_ERROR:   cmd.stop = 1'b1;
        OP_LOCAL_WRITE: cmd.wr_local = 1'b1;
        OP_LOCAL_READ:  cmd.rd_local = 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/i2crm_dp.sv
// Datapath: register file memory with per-entry valid bits, pointer,
// and result registers. Depends on i2crm_pkg; commanded by i2crm_ctrl.
`default_nettype none

module i2crm_dp
  import i2crm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] local_address,
  input  wire logic [7:0] local_value,
  output logic            ack,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            stop_recover,
  output logic [7:0]      local_read_data
);

  logic [7:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;

  logic [6:0] ptr;
  logic loaded;
  logic [7:0] ptr_inc;
  logic [7:0] rd_idx, wr_idx, wr_data;
  logic rd_en, wr_en, rd_in_range;

  logic [7:0] rd_q;
  logic rd_vld, rd_oor, lrd_sel;
  logic [7:0] rd_byte;

  assign ptr_inc = {1'b0, ptr} + 8'd1;
  assign sts.loaded = loaded;
  assign sts.can_inc = ({1'b0, ptr_inc} < REG_LIMIT);

  always_comb begin
    if (cmd.rd_local) rd_idx = local_address;
    else if (cmd.rd_next) rd_idx = ptr_inc;
    else rd_idx = {1'b0, ptr};
    if (cmd.wr_local) begin
      wr_idx = local_address;
      wr_data = local_value;
    end else begin
      wr_idx = {1'b0, ptr};
      wr_data = rx_byte;
    end
  end

  assign rd_en = cmd.rd_ptr || cmd.rd_next || cmd.rd_local;
  assign rd_in_range = ({1'b0, rd_idx} < REG_LIMIT);
  assign wr_en = (cmd.wr_ptr || cmd.wr_local) && ({1'b0, wr_idx} < REG_LIMIT);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx[IDX_W-1:0]] <= wr_data;
    if (rd_en) rd_q <= mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (wr_en) vld[wr_idx[IDX_W-1:0]] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      loaded <= 1'b0;
    end else begin
      if (cmd.rd_next) ptr <= ptr_inc[6:0];
      else if (cmd.set_ptr) ptr <= rx_byte[6:0];
      if (cmd.set_ptr) loaded <= 1'b1;
      else if (cmd.clr_loaded) loaded <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack <= 1'b0;
      tx_valid <= 1'b0;
      stop_recover <= 1'b0;
      lrd_sel <= 1'b0;
    end else if (cmd.load) begin
      ack <= cmd.ack;
      tx_valid <= cmd.rd_ptr || cmd.rd_next;
      stop_recover <= cmd.stop;
      lrd_sel <= cmd.rd_local;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld <= vld[rd_idx[IDX_W-1:0]];
      rd_oor <= !rd_in_range;
    end
  end

  assign rd_byte = rd_oor ? 8'hFF : (rd_vld ? rd_q : 8'h00);
  assign tx_byte = tx_valid ? rd_byte : 8'h00;
  assign local_read_data = lrd_sel ? rd_byte : 8'h00;

endmodule

`default_nettype wire

### sv/i2c_slave_register_map.sv
// I2C target register map, top level.
// Input channel (in_valid/in_ready) carries one bus event or local access per
// transfer: operation, rx_byte, local_address, local_value. Output channel
// (out_valid/out_ready) returns exactly one result per input transfer:
// ack, tx_valid, tx_byte, stop_recover, local_read_data.
// Latency: the result is presented the cycle after the input transfer.
// A new transfer is not accepted while a result is pending; the single
// result register is held until taken, and in_ready is low until then.
// The register file is a 128 x 8 memory with a registered read port; a bank
// of per-entry valid bits makes unwritten entries read as zero.
// Reset clears the pointer, the pointer-loaded flag and all valid bits
// at once; no clearing pass is needed. When out_ready is low the result holds
// steady and no new input is accepted.
// Depends on i2crm_pkg, i2crm_ctrl and i2crm_dp.
`default_nettype none

module i2c_slave_register_map
  import i2crm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] operation,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] local_address,
  input  wire logic [7:0] local_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            ack,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            stop_recover,
  output logic [7:0]      local_read_data
);

  cmd_t cmd;
  sts_t sts;

  i2crm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2crm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .rx_byte         (rx_byte),
    .local_address   (local_address),
    .local_value     (local_value),
    .ack             (ack),
    .tx_valid        (tx_valid),
    .tx_byte         (tx_byte),
    .stop_recover    (stop_recover),
    .local_read_data (local_read_data)
  );

endmodule

`default_nettype wire
